// ----- design/cbc_pkg.sv -----
// Shared types and constants for the cartridge bank controller.
package cbc_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned MapW     = 21;
  localparam int unsigned RomBankW = 7;
  localparam int unsigned RamBankW = 2;
  localparam int unsigned KindW    = 2;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  typedef enum logic [KindW-1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2,
    KIND_RSVD = 2'd3
  } mbc_kind_e;

  typedef enum logic [1:0] {
    TGT_DROP  = 2'd0,
    TGT_ROM   = 2'd1,
    TGT_RAM   = 2'd2,
    TGT_OTHER = 2'd3
  } target_e;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  localparam logic [3:0] RamEnableCode  = 4'hA;
  localparam logic [3:0] RamDisableCode = 4'h0;

  typedef struct packed {
    logic [RomBankW-1:0] rom_bank;
    logic [RamBankW-1:0] ram_bank;
    logic                ram_enable;
    logic                rom_mode;
  } bank_state_t;

endpackage

// ----- design/cartridge_bank_controller_core.sv -----
// Top level of the cartridge bank controller: decode, mapping and result register.
// An accepted input transaction's result is in the output register from the next cycle.
// Throughput: one transaction per cycle unless stalled; output frees on the edge it is taken.
// Input stall follows only a held result that is stalled at the output.
// Reset: rom_bank 1, ram_bank 0, RAM disabled, ROM mode, mbc_kind 0, output empty.
module cartridge_bank_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbc_pkg::PaddrW-1:0]   paddr,
  input  logic [cbc_pkg::PdataW-1:0]   pwdata,
  output logic [cbc_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [cbc_pkg::AddrW-1:0]    bus_address_i,
  input  logic [cbc_pkg::DataW-1:0]    write_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   target_o,
  output logic [cbc_pkg::MapW-1:0]     mapped_address_o,
  output logic                         ram_write_strobe_o,
  output logic [cbc_pkg::RomBankW-1:0] rom_bank_now_o,
  output logic [cbc_pkg::RamBankW-1:0] ram_bank_now_o,
  output logic                         ram_enabled_now_o
);
  import cbc_pkg::*;

  mbc_kind_e           kind_q;
  logic                cfg_wr;
  logic                accept;
  logic                bank_wr;
  logic                in_rom, in_ram;
  bank_state_t         cur, nxt;
  target_e             tgt_d, tgt_q;
  logic [MapW-1:0]     map_d, map_q;
  logic                strobe_d, strobe_q;
  bank_state_t         now_q;
  logic                valid_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[PaddrW-1:2] == '0);
  assign prdata = (paddr[PaddrW-1:2] == '0) ? PdataW'(kind_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_NONE;
    end else if (cfg_wr) begin
      kind_q <= mbc_kind_e'(pwdata[KindW-1:0]);
    end
  end

  assign in_stall_o = valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign bank_wr    = accept && (opcode_i == OP_WRITE) && !bus_address_i[15];

  cbc_bank_regs u_bank_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (bank_wr),
    .addr_i  (bus_address_i),
    .data_i  (write_data_i),
    .kind_i  (kind_q),
    .state_o (cur),
    .next_o  (nxt)
  );

  assign in_rom = (bus_address_i[15:14] == 2'b01);
  assign in_ram = (bus_address_i[15:13] == 3'b101);

  always_comb begin
    tgt_d    = TGT_OTHER;
    map_d    = MapW'(bus_address_i);
    strobe_d = 1'b0;
    if (opcode_i == OP_READ) begin
      if (in_rom) begin
        tgt_d = TGT_ROM;
        map_d = {cur.rom_bank, bus_address_i[13:0]};
      end else if (in_ram) begin
        tgt_d = TGT_RAM;
        map_d = MapW'({cur.ram_bank, bus_address_i[12:0]});
      end
    end else if (!bus_address_i[15]) begin
      tgt_d = TGT_DROP;
      map_d = '0;
    end else if (in_ram) begin
      if (cur.ram_enable) begin
        tgt_d    = TGT_RAM;
        map_d    = MapW'({cur.ram_bank, bus_address_i[12:0]});
        strobe_d = 1'b1;
      end else begin
        tgt_d = TGT_DROP;
        map_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_q    <= tgt_d;
      map_q    <= map_d;
      strobe_q <= strobe_d;
      now_q    <= nxt;
    end
  end

  assign out_valid_o        = valid_q;
  assign target_o           = tgt_q;
  assign mapped_address_o   = map_q;
  assign ram_write_strobe_o = strobe_q;
  assign rom_bank_now_o     = now_q.rom_bank;
  assign ram_bank_now_o     = now_q.ram_bank;
  assign ram_enabled_now_o  = now_q.ram_enable;

endmodule

// ----- design/cbc_bank_regs.sv -----
// Bank registers and their update on writes below 0x8000.
module cbc_bank_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [cbc_pkg::AddrW-1:0] addr_i,
  input  logic [cbc_pkg::DataW-1:0] data_i,
  input  cbc_pkg::mbc_kind_e        kind_i,
  output cbc_pkg::bank_state_t      state_o,
  output cbc_pkg::bank_state_t      next_o
);
  import cbc_pkg::*;

  bank_state_t state_q, upd, state_d;
  logic        k1, k2;

  assign k1 = (kind_i == KIND_MBC1);
  assign k2 = (kind_i == KIND_MBC2);

  always_comb begin
    upd = state_q;
    case (addr_i[14:13])
      2'd0: begin
        if ((k1 || k2) && !(k2 && addr_i[4])) begin
          if (data_i[3:0] == RamEnableCode) begin
            upd.ram_enable = 1'b1;
          end else if (data_i[3:0] == RamDisableCode) begin
            upd.ram_enable = 1'b0;
          end
        end
      end
      2'd1: begin
        if (k2) begin
          upd.rom_bank = {3'b000, data_i[3:0]};
        end else if (k1) begin
          upd.rom_bank = {state_q.rom_bank[6:5], data_i[4:0]};
        end
        if ((k1 || k2) && upd.rom_bank == '0) begin
          upd.rom_bank = RomBankW'(1);
        end
      end
      2'd2: begin
        if (k1) begin
          if (state_q.rom_mode) begin
            upd.rom_bank = {data_i[1:0], state_q.rom_bank[4:0]};
            if (upd.rom_bank == '0) begin
              upd.rom_bank = RomBankW'(1);
            end
          end else begin
            upd.ram_bank = data_i[1:0];
          end
        end
      end
      default: begin
        if (k1) begin
          upd.rom_mode = ~data_i[0];
          if (~data_i[0]) begin
            upd.ram_bank = '0;
          end
        end
      end
    endcase
  end

  assign state_d = wr_en_i ? upd : state_q;
  assign state_o = state_q;
  assign next_o  = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{rom_bank: RomBankW'(1), ram_bank: '0, ram_enable: 1'b0, rom_mode: 1'b1};
    end else begin
      state_q <= state_d;
    end
  end

endmodule
